// ===== hdl/scc_pkg.sv =====
`default_nettype none
package scc_pkg;

  localparam int NUM_CAL  = 8;
  localparam int NUM_ST   = 48;
  localparam int DIV_FRST = 12;
  localparam int DIV_BITS = 32;

  localparam logic [2:0] REG_T12   = 3'd0;
  localparam logic [2:0] REG_T3P1  = 3'd1;
  localparam logic [2:0] REG_P23   = 3'd2;
  localparam logic [2:0] REG_P45   = 3'd3;
  localparam logic [2:0] REG_P67   = 3'd4;
  localparam logic [2:0] REG_P89   = 3'd5;
  localparam logic [2:0] REG_H1    = 3'd6;
  localparam logic [2:0] REG_H2    = 3'd7;

  localparam logic [31:0] C_T_OFS   = 32'd64000;
  localparam logic [31:0] C_H_OFS   = 32'd76800;
  localparam logic [31:0] C_P_BASE  = 32'd1048576;
  localparam logic [31:0] C_P_MUL   = 32'd3125;
  localparam logic [31:0] C_HALF    = 32'h8000_0000;
  localparam logic [31:0] C_Z_OFS   = 32'd2097152;
  localparam logic [31:0] C_RND14   = 32'd16384;
  localparam logic [31:0] C_ONE15   = 32'd32768;
  localparam logic [31:0] C_RND13   = 32'd8192;
  localparam logic [31:0] C_HUM_MAX = 32'd419430400;
  localparam logic [23:0] C_P_MAX   = 24'hFF_FFFF;

  typedef struct packed {
    logic        v;
    logic [19:0] adcp;
    logic [15:0] adch;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] tfine;
    logic [31:0] q1;
    logic [31:0] x;
    logic [31:0] hh;
    logic [31:0] mq5;
    logic [31:0] mp2;
    logic [31:0] hx5;
    logic [31:0] xh6;
    logic [31:0] xh3;
    logic [31:0] q2;
    logic [31:0] tp3;
    logic [31:0] y;
    logic [31:0] za;
    logic [31:0] zb;
    logic [31:0] z;
    logic [31:0] n;
    logic [31:0] rem;
    logic [31:0] q;
    logic        dbl;
    logic        err;
    logic [31:0] hx;
    logic [31:0] hsq;
    logic [6:0]  hum;
    logic [15:0] temp;
    logic [31:0] p;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [23:0] press;
  } pipe_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sensor_calibration_compensation.sv =====
// Integer compensation of raw temperature, pressure and humidity readings.
// One transfer on in_ carries the three raw readings and yields exactly one
// transfer on out_ with temperature in 0.01 degC (saturated), pressure in Pa
// (saturated, zero with out_tuser set when the pressure divisor is zero) and
// humidity in whole percent. A new item can be taken every cycle unless the
// output stalls. Pressure passes a 32-stage restoring divider, one
// quotient bit per stage. The whole pipeline advances together and holds when
// out_tready is low with a result waiting. Calibration words must be written
// via cfg_ only while no item is in flight; the block does not enforce this.
`default_nettype none
module sensor_calibration_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // temperature_centi[15:0], pressure_pa[39:16], humidity_percent[46:40], zero pad
  output logic [47:0]      out_tdata,
  // status[0]
  output logic             out_tuser,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0] cal_r [scc_pkg::NUM_CAL];
  scc_pkg::pipe_t st_r   [scc_pkg::NUM_ST];
  scc_pkg::pipe_t st_nxt [scc_pkg::NUM_ST];
  logic en;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'd0, cal_r[scc_pkg::REG_T12][15:0]};
  assign t2 = scc_pkg::sx16(cal_r[scc_pkg::REG_T12][31:16]);
  assign t3 = scc_pkg::sx16(cal_r[scc_pkg::REG_T3P1][15:0]);
  assign p1 = {16'd0, cal_r[scc_pkg::REG_T3P1][31:16]};
  assign p2 = scc_pkg::sx16(cal_r[scc_pkg::REG_P23][15:0]);
  assign p3 = scc_pkg::sx16(cal_r[scc_pkg::REG_P23][31:16]);
  assign p4 = scc_pkg::sx16(cal_r[scc_pkg::REG_P45][15:0]);
  assign p5 = scc_pkg::sx16(cal_r[scc_pkg::REG_P45][31:16]);
  assign p6 = scc_pkg::sx16(cal_r[scc_pkg::REG_P67][15:0]);
  assign p7 = scc_pkg::sx16(cal_r[scc_pkg::REG_P67][31:16]);
  assign p8 = scc_pkg::sx16(cal_r[scc_pkg::REG_P89][15:0]);
  assign p9 = scc_pkg::sx16(cal_r[scc_pkg::REG_P89][31:16]);
  assign h1 = {24'd0, cal_r[scc_pkg::REG_H1][7:0]};
  assign h2 = scc_pkg::sx16(cal_r[scc_pkg::REG_H1][23:8]);
  assign h3 = {24'd0, cal_r[scc_pkg::REG_H1][31:24]};
  assign h4 = {{20{cal_r[scc_pkg::REG_H2][11]}}, cal_r[scc_pkg::REG_H2][11:0]};
  assign h5 = {{20{cal_r[scc_pkg::REG_H2][23]}}, cal_r[scc_pkg::REG_H2][23:12]};
  assign h6 = {{24{cal_r[scc_pkg::REG_H2][31]}}, cal_r[scc_pkg::REG_H2][31:24]};

  assign en        = !st_r[scc_pkg::NUM_ST-1].v || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < scc_pkg::NUM_CAL; k++) cal_r[k] <= '0;
    end else if (cfg_we) begin
      cal_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    logic signed [34:0] tv;
    logic signed [34:0] ts;
    logic [32:0] rr;
    logic [31:0] hv;
    logic [31:0] pq;
    scc_pkg::pipe_t s;

    for (int k = 0; k < scc_pkg::NUM_ST; k++) st_nxt[k] = st_r[k];

    // input capture and first differences
    s = st_r[0];
    s.v    = in_tvalid;
    s.adcp = in_tdata[39:20];
    s.adch = in_tdata[55:40];
    s.a    = {15'd0, in_tdata[19:3]} - {t1[30:0], 1'b0};
    s.b    = {16'd0, in_tdata[19:4]} - t1;
    st_nxt[0] = s;

    s = st_r[0];
    s.m1 = 32'(s.a * t2);
    s.m2 = 32'(s.b * s.b);
    st_nxt[1] = s;

    s = st_r[1];
    s.m1 = scc_pkg::asr(s.m1, 11);
    s.m2 = 32'(scc_pkg::asr(s.m2, 12) * t3);
    st_nxt[2] = s;

    s = st_r[2];
    s.tfine = s.m1 + scc_pkg::asr(s.m2, 14);
    st_nxt[3] = s;

    // temperature out; floor division by 256 is an arithmetic shift
    s = st_r[3];
    tv = $signed({{3{s.tfine[31]}}, s.tfine}) * 35'sd5 + 35'sd128;
    ts = tv >>> 8;
    if (ts > 35'sd32767) s.temp = 16'h7FFF;
    else if (ts < -35'sd32768) s.temp = 16'h8000;
    else s.temp = ts[15:0];
    s.q1 = scc_pkg::asr(s.tfine, 1) - scc_pkg::C_T_OFS;
    s.x  = s.tfine - scc_pkg::C_H_OFS;
    st_nxt[4] = s;

    s = st_r[4];
    s.hh  = 32'(scc_pkg::asr(s.q1, 2) * scc_pkg::asr(s.q1, 2));
    s.mq5 = 32'(s.q1 * p5);
    s.mp2 = 32'(p2 * s.q1);
    s.hx5 = 32'(h5 * s.x);
    s.xh6 = 32'(s.x * h6);
    s.xh3 = 32'(s.x * h3);
    st_nxt[5] = s;

    s = st_r[5];
    s.q2  = 32'(scc_pkg::asr(s.hh, 11) * p6);
    s.tp3 = 32'(p3 * scc_pkg::asr(s.hh, 13));
    s.y   = (({16'd0, s.adch} << 14) - (h4 << 20) - s.hx5) + scc_pkg::C_RND14;
    s.za  = scc_pkg::asr(s.xh6, 10);
    s.zb  = scc_pkg::asr(s.xh3, 11) + scc_pkg::C_ONE15;
    st_nxt[6] = s;

    s = st_r[6];
    s.q2 = s.q2 + {s.mq5[30:0], 1'b0};
    s.q1 = scc_pkg::asr(scc_pkg::asr(s.tp3, 3) + scc_pkg::asr(s.mp2, 1), 18);
    s.y  = scc_pkg::asr(s.y, 15);
    s.z  = 32'(s.za * s.zb);
    st_nxt[7] = s;

    s = st_r[7];
    s.q2 = scc_pkg::asr(s.q2, 2) + (p4 << 16);
    s.q1 = 32'((scc_pkg::C_ONE15 + s.q1) * p1);
    s.z  = scc_pkg::asr(s.z, 10) + scc_pkg::C_Z_OFS;
    st_nxt[8] = s;

    s = st_r[8];
    s.q1 = scc_pkg::asr(s.q1, 15);
    s.p  = (scc_pkg::C_P_BASE - {12'd0, s.adcp}) - scc_pkg::asr(s.q2, 12);
    s.z  = 32'(s.z * h2);
    st_nxt[9] = s;

    s = st_r[9];
    s.p = 32'(s.p * scc_pkg::C_P_MUL);
    s.z = scc_pkg::asr(s.z + scc_pkg::C_RND13, 14);
    st_nxt[10] = s;

    // divider set-up: small dividends are doubled before, large ones after
    s = st_r[10];
    s.err = (s.q1 == '0);
    s.dbl = (s.p >= scc_pkg::C_HALF);
    s.n   = s.dbl ? s.p : {s.p[30:0], 1'b0};
    s.rem = '0;
    s.q   = '0;
    s.hx  = 32'(s.y * s.z);
    st_nxt[11] = s;

    for (int i = 0; i < scc_pkg::DIV_BITS; i++) begin
      s = st_r[scc_pkg::DIV_FRST + i - 1];
      rr = {s.rem, s.n[31]};
      s.n = {s.n[30:0], 1'b0};
      if (rr >= {1'b0, s.q1}) begin
        rr  = rr - {1'b0, s.q1};
        s.q = {s.q[30:0], 1'b1};
      end else begin
        s.q = {s.q[30:0], 1'b0};
      end
      s.rem = rr[31:0];
      st_nxt[scc_pkg::DIV_FRST + i] = s;
    end

    // humidity tail rides along the first divider stages
    st_nxt[12].hsq = 32'(scc_pkg::asr(st_r[11].hx, 15) * scc_pkg::asr(st_r[11].hx, 15));
    st_nxt[13].hsq = 32'(scc_pkg::asr(st_r[12].hsq, 7) * h1);
    st_nxt[14].hx  = st_r[13].hx - scc_pkg::asr(st_r[13].hsq, 4);
    hv = st_r[14].hx;
    if (hv[31]) st_nxt[15].hum = '0;
    else if (hv > scc_pkg::C_HUM_MAX) st_nxt[15].hum = scc_pkg::C_HUM_MAX[28:22];
    else st_nxt[15].hum = hv[28:22];

    s = st_r[43];
    pq = s.dbl ? {s.q[30:0], 1'b0} : s.q;
    s.p  = pq;
    s.r1 = 32'({3'd0, pq[31:3]} * {3'd0, pq[31:3]});
    s.r2 = 32'({2'd0, pq[31:2]} * p8);
    st_nxt[44] = s;

    s = st_r[44];
    s.r1 = 32'(p9 * {13'd0, s.r1[31:13]});
    s.r2 = scc_pkg::asr(s.r2, 13);
    st_nxt[45] = s;

    s = st_r[45];
    s.p = s.p + scc_pkg::asr(scc_pkg::asr(s.r1, 12) + s.r2 + p7, 4);
    st_nxt[46] = s;

    s = st_r[46];
    if (s.err || s.p[31]) s.press = '0;
    else if (s.p > {8'd0, scc_pkg::C_P_MAX}) s.press = scc_pkg::C_P_MAX;
    else s.press = s.p[23:0];
    st_nxt[47] = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < scc_pkg::NUM_ST; k++) st_r[k].v <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < scc_pkg::NUM_ST; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign out_tvalid = st_r[scc_pkg::NUM_ST-1].v;
  assign out_tdata  = {1'b0, st_r[scc_pkg::NUM_ST-1].hum, st_r[scc_pkg::NUM_ST-1].press,
                       st_r[scc_pkg::NUM_ST-1].temp};
  assign out_tuser  = st_r[scc_pkg::NUM_ST-1].err;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[39:16] == 24'd0)
    else $error("pressure not zero on divisor error");

  a_hum_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[46:40] <= 7'd100)
    else $error("humidity above 100 percent");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline stalled");

endmodule
`default_nettype wire
